/* hdl/ffa_pkg.sv */
`default_nettype none
package ffa_pkg;
	localparam int MEM_BYTES = 128;
	localparam int MAX_BLOCKS = 128;
	localparam int HANDLE_BITS = 16;
	localparam int IDX_BITS = $clog2(MAX_BLOCKS);
	localparam int CNT_BITS = $clog2(MAX_BLOCKS + 1);
	localparam int ADDR_BITS = $clog2(MEM_BYTES + 1) + 1;
	localparam int ENTRY_BITS = HANDLE_BITS + ADDR_BITS + 8;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_ERASE = 2'd1;
	localparam logic [1:0] OP_DEFRAG = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] request_size;
		logic [15:0] erase_handle;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [15:0] new_handle;
	} out_item_t;

	typedef struct packed {
		logic [HANDLE_BITS-1:0] handle;
		logic [ADDR_BITS-1:0] start;
		logic [7:0] length;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN,
		S_SHUP_RD,
		S_SHUP_WR,
		S_INSERT,
		S_SHDN_RD,
		S_SHDN_WR,
		S_DEF_RD,
		S_DEF_WR,
		S_RESULT
	} state_t;
endpackage
`default_nettype wire

/* hdl/ffa_ram.sv */
`default_nettype none
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hdl/first_fit_allocator_compaction_core.sv */
`default_nettype none
// Each operation walks the block table held in one RAM, entry by entry.
// Allocate scans for the first gap that fits, shifts later entries up and
// inserts; erase scans, then shifts entries down; defragment packs each entry.
// One item at a time; the result register frees the core once taken.
// Reset (arst_n low) clears the counters and sets mem_size to 128;
// the table RAM is not cleared, since entries are written before read.
module first_fit_allocator_compaction_core
	import ffa_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [7:0] cfg_data
);
	state_t state_q, state_next;
	logic [7:0] mem_size_q;
	logic [CNT_BITS-1:0] live_q;
	logic [HANDLE_BITS-1:0] last_q;
	in_item_t item_q;
	logic [CNT_BITS-1:0] p_q, k_q;
	logic [ADDR_BITS-1:0] gs_q;
	logic out_valid_q;
	out_item_t out_q;

	logic we;
	logic [IDX_BITS-1:0] waddr, raddr;
	entry_t wdata, rdata;

	ffa_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_BLOCKS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [ADDR_BITS-1:0] mem_lim;
	logic [ADDR_BITS-1:0] ge;
	logic fits;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		mem_lim = (ADDR_BITS'(mem_size_q) > ADDR_BITS'(MEM_BYTES)) ? ADDR_BITS'(MEM_BYTES)
			: ADDR_BITS'(mem_size_q);
		ge = (p_q < live_q) ? rdata.start : mem_lim;
		// The gap is negative when memory shrank below a block; that never fits.
		fits = (ge >= gs_q) && ((ge - gs_q) >= ADDR_BITS'(item_q.request_size));
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				unique case (in_data.opcode)
					OP_ALLOC: state_next = S_SCAN_RD;
					OP_ERASE: state_next = S_SCAN_RD;
					OP_DEFRAG: state_next = S_DEF_RD;
					default: state_next = S_IDLE;
				endcase
			end
			S_SCAN_RD: begin
				if (item_q.opcode == OP_ALLOC && (live_q >= CNT_BITS'(MAX_BLOCKS)
					|| last_q == '1)) state_next = S_RESULT;
				else if (item_q.opcode == OP_ERASE && p_q >= live_q) state_next = S_RESULT;
				else state_next = S_SCAN;
			end
			S_SCAN: begin
				if (item_q.opcode == OP_ALLOC) begin
					if (fits) state_next = (live_q > p_q) ? S_SHUP_RD : S_INSERT;
					else if (p_q >= live_q) state_next = S_RESULT;
					else state_next = S_SCAN_RD;
				end else begin
					if (rdata.handle == HANDLE_BITS'(item_q.erase_handle))
						state_next = (p_q + 1'b1 < live_q) ? S_SHDN_RD : S_IDLE;
					else state_next = S_SCAN_RD;
				end
			end
			S_SHUP_RD: state_next = S_SHUP_WR;
			S_SHUP_WR: state_next = (k_q - 1'b1 > p_q) ? S_SHUP_RD : S_INSERT;
			S_INSERT: state_next = S_RESULT;
			S_SHDN_RD: state_next = S_SHDN_WR;
			S_SHDN_WR: state_next = (k_q + 2'd2 < live_q + 1'b1) ? S_SHDN_RD : S_IDLE;
			S_DEF_RD: state_next = (p_q < live_q) ? S_DEF_WR : S_IDLE;
			S_DEF_WR: state_next = S_DEF_RD;
			S_RESULT: state_next = S_IDLE;
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = rdata;
		raddr = IDX_BITS'(p_q);
		unique case (state_q)
			S_SHUP_RD: raddr = IDX_BITS'(k_q - 1'b1);
			S_SHUP_WR: begin
				we = 1'b1;
				waddr = IDX_BITS'(k_q);
			end
			S_INSERT: begin
				we = 1'b1;
				waddr = IDX_BITS'(p_q);
				wdata.handle = last_q + 1'b1;
				wdata.start = gs_q;
				wdata.length = item_q.request_size;
			end
			S_SHDN_RD: raddr = IDX_BITS'(k_q + 1'b1);
			S_SHDN_WR: begin
				we = 1'b1;
				waddr = IDX_BITS'(k_q);
			end
			S_DEF_WR: begin
				we = 1'b1;
				waddr = IDX_BITS'(p_q);
				wdata.start = gs_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mem_size_q <= 8'd128;
			live_q <= '0;
			last_q <= '0;
			out_valid_q <= 1'b0;
			p_q <= '0;
			k_q <= '0;
			gs_q <= '0;
		end else begin
			state_q <= state_next;
			if (cfg_valid) mem_size_q <= cfg_data;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					item_q <= in_data;
					p_q <= '0;
					gs_q <= '0;
				end
				S_SCAN_RD: begin
					if (state_next == S_RESULT) begin
						out_q.new_handle <= '0;
						out_q.status <= (item_q.opcode == OP_ALLOC) ? ST_FAIL : ST_ILLEGAL;
					end
				end
				S_SCAN: begin
					k_q <= (item_q.opcode == OP_ALLOC) ? live_q : p_q;
					if (item_q.opcode == OP_ALLOC && !fits) begin
						if (p_q >= live_q) begin
							out_q.status <= ST_FAIL;
							out_q.new_handle <= '0;
						end
						gs_q <= rdata.start + ADDR_BITS'(rdata.length);
						p_q <= p_q + 1'b1;
					end else if (item_q.opcode == OP_ERASE) begin
						if (rdata.handle == HANDLE_BITS'(item_q.erase_handle))
							live_q <= live_q - 1'b1;
						else p_q <= p_q + 1'b1;
					end
				end
				S_SHUP_WR: k_q <= k_q - 1'b1;
				S_INSERT: begin
					last_q <= last_q + 1'b1;
					live_q <= live_q + 1'b1;
					out_q.status <= ST_OK;
					out_q.new_handle <= 16'(last_q + 1'b1);
				end
				S_SHDN_WR: k_q <= k_q + 1'b1;
				S_DEF_WR: begin
					gs_q <= gs_q + ADDR_BITS'(rdata.length);
					p_q <= p_q + 1'b1;
				end
				S_RESULT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

/* bench/first_fit_allocator_compaction_core_test.sv */
`timescale 1ns / 100ps
`default_nettype none

class alloc_scoreboard;
	int unsigned mem_size;
	int unsigned blk_handle[$];
	int unsigned blk_start[$];
	int unsigned blk_length[$];
	int unsigned last_handle;
	ffa_pkg::out_item_t pending[$];
	int errors;
	int results_seen;

	function void clear();
		mem_size = 128;
		blk_handle.delete();
		blk_start.delete();
		blk_length.delete();
		last_handle = 0;
		pending.delete();
		errors = 0;
		results_seen = 0;
	endfunction

	function void note_input(ffa_pkg::in_item_t it);
		ffa_pkg::out_item_t r;
		int unsigned lim;
		int unsigned gs;
		int unsigned ge;
		int unsigned pos;
		int found;
		lim = (mem_size < ffa_pkg::MEM_BYTES) ? mem_size : ffa_pkg::MEM_BYTES;
		case (it.opcode)
			ffa_pkg::OP_ALLOC: begin
				r.status = ffa_pkg::ST_FAIL;
				r.new_handle = '0;
				if (blk_handle.size() < ffa_pkg::MAX_BLOCKS && last_handle < 16'hFFFF) begin
					for (int p = 0; p <= blk_handle.size(); p++) begin
						gs = (p > 0) ? blk_start[p-1] + blk_length[p-1] : 0;
						ge = (p < blk_handle.size()) ? blk_start[p] : lim;
						// A shrunk memory can leave blocks past the end; that gap is empty.
						if (ge >= gs && ge - gs >= it.request_size) begin
							last_handle++;
							blk_handle.insert(p, last_handle);
							blk_start.insert(p, gs);
							blk_length.insert(p, it.request_size);
							r.status = ffa_pkg::ST_OK;
							r.new_handle = last_handle[15:0];
							break;
						end
					end
				end
				pending.push_back(r);
			end
			ffa_pkg::OP_ERASE: begin
				found = -1;
				foreach (blk_handle[i])
					if (found < 0 && blk_handle[i] == it.erase_handle) found = i;
				if (found >= 0) begin
					blk_handle.delete(found);
					blk_start.delete(found);
					blk_length.delete(found);
				end else begin
					r.status = ffa_pkg::ST_ILLEGAL;
					r.new_handle = '0;
					pending.push_back(r);
				end
			end
			ffa_pkg::OP_DEFRAG: begin
				pos = 0;
				foreach (blk_start[i]) begin
					blk_start[i] = pos;
					pos += blk_length[i];
				end
			end
			default: ;
		endcase
	endfunction

	function void check_result(ffa_pkg::out_item_t got);
		ffa_pkg::out_item_t want;
		results_seen++;
		if (pending.size() == 0) begin
			$error("result with nothing expected: status %0d handle %0d",
				got.status, got.new_handle);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, got.status);
			errors++;
		end
		if (got.new_handle !== want.new_handle) begin
			$error("new_handle: expected %0d, actual %0d", want.new_handle, got.new_handle);
			errors++;
		end
	endfunction
endclass

module first_fit_allocator_compaction_core_test;
	import ffa_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = 8'd128;

	alloc_scoreboard board = new();
	int idle_cycles = 0;
	int items_sent = 0;
	bit sink_quiet = 1'b0;
	localparam int WATCHDOG = 20000;

	first_fit_allocator_compaction_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Result side: accept transfers, stall at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(out_data);
		if (!sink_quiet && (in_valid || cfg_valid || board.pending.size() != 0) &&
				($urandom_range(0, 99) < 15 || (out_ready == 1'b0 && $urandom_range(0, 9) == 0)))
			out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ~out_ready;
		else
			out_ready <= (sink_quiet) ? 1'b1 : out_ready | ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("watchdog expired");
			$display("FAILURE");
			$finish;
		end
	end

	// Valid stays high after a transfer when the next item follows with no gap.
	task automatic send_item(logic [1:0] op, logic [7:0] sz, logic [15:0] h);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_data <= '{opcode: op, request_size: sz, erase_handle: h};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_input('{opcode: op, request_size: sz, erase_handle: h});
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		// An erase or defragment may still be walking the table.
		repeat (300) @(posedge clk);
	endtask

	task automatic write_mem_size(logic [7:0] v);
		drain();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.mem_size = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_handle();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6 && board.blk_handle.size() != 0)
			return 16'(board.blk_handle[$urandom_range(0, board.blk_handle.size() - 1)]);
		if (r < 8) return 16'($urandom_range(0, board.last_handle + 2));
		return 16'($urandom());
	endfunction

	task automatic random_phase(int n, int max_sz);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				send_item(OP_ALLOC, 8'($urandom_range(0, max_sz)), 16'($urandom()));
			else if (r < 85) send_item(OP_ERASE, 8'($urandom()), pick_handle());
			else if (r < 95) send_item(OP_DEFRAG, 8'($urandom()), 16'($urandom()));
			else send_item(2'd3, 8'($urandom()), 16'($urandom()));
		end
	endtask

	initial begin
		board.clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every opcode, zero-size and unknown-handle cases.
		send_item(OP_ALLOC, 8'd0, 16'd0);
		send_item(OP_ALLOC, 8'd255, 16'hFFFF);
		send_item(OP_ALLOC, 8'd128, 16'd0);
		send_item(OP_ALLOC, 8'd1, 16'd0);
		send_item(OP_ERASE, 8'd0, 16'd0);
		send_item(OP_ERASE, 8'hFF, 16'hFFFF);
		send_item(OP_ERASE, 8'd0, 16'd1);
		send_item(OP_ERASE, 8'd0, 16'd1);
		send_item(OP_DEFRAG, 8'hFF, 16'hFFFF);
		send_item(2'd3, 8'hFF, 16'hFFFF);
		send_item(OP_ALLOC, 8'd127, 16'd0);
		send_item(OP_ALLOC, 8'd0, 16'd0);
		send_item(OP_ERASE, 8'd0, 16'd4);
		send_item(OP_DEFRAG, 8'd0, 16'd0);
		send_item(OP_ALLOC, 8'd1, 16'd0);
		write_mem_size(8'd255);
		send_item(OP_ALLOC, 8'd1, 16'd0);
		write_mem_size(8'd1);
		send_item(OP_ALLOC, 8'd1, 16'd0);
		send_item(OP_ALLOC, 8'd0, 16'd0);
		send_item(OP_DEFRAG, 8'd0, 16'd0);

		// Sender holds off until every result is back.
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);

		write_mem_size(8'd128);
		random_phase(300, 40);
		write_mem_size(8'd37);
		random_phase(250, 20);
		write_mem_size(8'd200);
		random_phase(250, 130);
		// Zero-byte blocks fill the table to its limit.
		write_mem_size(8'd4);
		while (board.blk_handle.size() < MAX_BLOCKS)
			send_item(OP_ALLOC, 8'd0, 16'd0);
		send_item(OP_ALLOC, 8'd0, 16'd0);
		write_mem_size(8'd1);
		random_phase(150, 2);
		write_mem_size(8'd90);
		random_phase(350, 16);

		drain();
		sink_quiet = 1'b1;
		repeat (50) @(posedge clk);
		$display("Sent %0d items over seven memory sizes and checked %0d results.",
			items_sent, board.results_seen);
		if (board.pending.size() != 0) begin
			$error("%0d results never arrived", board.pending.size());
			board.errors++;
		end
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

`default_nettype wire

/* first_fit_allocator_compaction_core.f */
hdl/ffa_pkg.sv
hdl/ffa_ram.sv
hdl/first_fit_allocator_compaction_core.sv
bench/first_fit_allocator_compaction_core_test.sv
